/* hdl/vns_pkg.sv */
// Shared types and constants of the Voronoi nearest-seed shader.
package vns_pkg;

  localparam int DEF_MAX_SEEDS  = 64;
  localparam int DEF_COORD_BITS = 10;

  localparam int CNT_W      = 7;
  localparam int RAD_W      = 21;
  localparam int IDX_OUT_W  = 6;
  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam int CELL_ID_W  = 9;

  localparam logic [CNT_W-1:0] RESET_SEED_COUNT    = 7'd50;
  localparam logic [RAD_W-1:0] RESET_MARKER_RADIUS = 21'd10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_COUNT    = 1'b0,
    CFG_MARKER_RADIUS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                 valid;
    logic                 load;
    logic                 marker;
    logic [IDX_OUT_W-1:0] seed_index;
  } vns_ctl_t;

endpackage

/* hdl/vns_if.sv */
// Input and result channel interfaces of the Voronoi nearest-seed shader.
interface vns_in_if import vns_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IDX_OUT_W-1:0]  seed_index;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [CHAN_W-1:0]     load_red;
  logic [CHAN_W-1:0]     load_green;
  logic [CHAN_W-1:0]     load_blue;

  modport source (
    output valid, op, seed_index, pos_x, pos_y, load_red, load_green, load_blue,
    input  ready
  );
  modport sink (
    input  valid, op, seed_index, pos_x, pos_y, load_red, load_green, load_blue,
    output ready
  );
endinterface

interface vns_out_if import vns_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_W-1:0]    pixel_red;
  logic [CHAN_W-1:0]    pixel_green;
  logic [CHAN_W-1:0]    pixel_blue;
  logic [IDX_OUT_W-1:0] nearest_index;
  logic                 on_marker;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, nearest_index, on_marker,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, nearest_index, on_marker,
    output ready
  );
endinterface

/* hdl/vns_cell.sv */
// One seed cell: holds a seed and updates the running nearest-seed search.
module vns_cell import vns_pkg::*; #(
  parameter int CELL_ID    = 0,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int IDX_W      = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [CNT_W-1:0]          seed_count,
  input  logic [RAD_W-1:0]          marker_radius,
  input  vns_ctl_t                  ctl_i,
  input  logic [COORD_BITS-1:0]     pos_x_i,
  input  logic [COORD_BITS-1:0]     pos_y_i,
  input  logic [RGB_W-1:0]          rgb_i,
  input  logic [2*COORD_BITS:0]     best_d_i,
  input  logic [IDX_W-1:0]          best_i_i,
  input  logic [RGB_W-1:0]          best_rgb_i,
  output vns_ctl_t                  ctl_o,
  output logic [COORD_BITS-1:0]     pos_x_o,
  output logic [COORD_BITS-1:0]     pos_y_o,
  output logic [RGB_W-1:0]          rgb_o,
  output logic [2*COORD_BITS:0]     best_d_o,
  output logic [IDX_W-1:0]          best_i_o,
  output logic [RGB_W-1:0]          best_rgb_o
);

  localparam int D_W   = 2 * COORD_BITS + 1;
  localparam int CMP_W = (D_W > RAD_W) ? D_W : RAD_W;

  logic [COORD_BITS-1:0]   seed_x_r;
  logic [COORD_BITS-1:0]   seed_y_r;
  logic [RGB_W-1:0]        seed_rgb_r;

  vns_ctl_t                ctl_r;
  vns_ctl_t                ctl_nxt;
  logic [COORD_BITS-1:0]   pos_x_r;
  logic [COORD_BITS-1:0]   pos_y_r;
  logic [RGB_W-1:0]        rgb_r;
  logic [D_W-1:0]          best_d_r;
  logic [IDX_W-1:0]        best_i_r;
  logic [RGB_W-1:0]        best_rgb_r;

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] sq_x;
  logic [2*COORD_BITS-1:0] sq_y;
  logic [D_W-1:0]          cur_d;
  logic                    active;
  logic                    shade;
  logic                    take;
  logic                    near;
  logic                    loading;

  always_comb begin
    dx      = (pos_x_i >= seed_x_r) ? (pos_x_i - seed_x_r) : (seed_x_r - pos_x_i);
    dy      = (pos_y_i >= seed_y_r) ? (pos_y_i - seed_y_r) : (seed_y_r - pos_y_i);
    sq_x    = dx * dx;
    sq_y    = dy * dy;
    cur_d   = {1'b0, sq_x} + {1'b0, sq_y};
    active  = (CELL_ID == 0) ||
              (CELL_ID_W'(CELL_ID) < CELL_ID_W'(seed_count));
    shade   = ctl_i.valid && !ctl_i.load;
    take    = shade && active && (cur_d < best_d_i);
    near    = shade && active && (CMP_W'(cur_d) <= CMP_W'(marker_radius));
    loading = adv && ctl_i.valid && ctl_i.load &&
              (CELL_ID_W'(ctl_i.seed_index) == CELL_ID_W'(CELL_ID));
    ctl_nxt        = ctl_i;
    ctl_nxt.marker = ctl_i.marker | near;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r    <= pos_x_i;
      pos_y_r    <= pos_y_i;
      rgb_r      <= rgb_i;
      best_d_r   <= take ? cur_d : best_d_i;
      best_i_r   <= take ? IDX_W'(CELL_ID) : best_i_i;
      best_rgb_r <= take ? seed_rgb_r : best_rgb_i;
    end
    if (loading) begin
      seed_x_r   <= pos_x_i;
      seed_y_r   <= pos_y_i;
      seed_rgb_r <= rgb_i;
    end
  end

  assign ctl_o      = ctl_r;
  assign pos_x_o    = pos_x_r;
  assign pos_y_o    = pos_y_r;
  assign rgb_o      = rgb_r;
  assign best_d_o   = best_d_r;
  assign best_i_o   = best_i_r;
  assign best_rgb_o = best_rgb_r;

endmodule

/* hdl/voronoi_nearest_seed_shader.sv */
// Top level of the Voronoi nearest-seed shader: seed cell chain and result register.
// An accepted pixel word passes the MAX_SEEDS seed cell registers, then the result register.
// Throughput: one word per cycle unless stalled; every word walks the chain of MAX_SEEDS
// seed cells, one cell per cycle, and a load word writes its seed as it passes its cell.
// A stalled result word freezes the whole chain and the input.
// Reset: synchronous, active low; clears the chain and result valid bits and
// restores seed_count to 50 and marker_radius to 10; seed storage is not cleared.
module voronoi_nearest_seed_shader import vns_pkg::*; #(
  parameter int MAX_SEEDS  = DEF_MAX_SEEDS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vns_in_if.sink                in_ch,
  vns_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int D_W   = 2 * COORD_BITS + 1;

  logic [CNT_W-1:0]      seed_count_r;
  logic [RAD_W-1:0]      marker_radius_r;

  vns_ctl_t              ctl      [MAX_SEEDS+1];
  logic [COORD_BITS-1:0] pos_x    [MAX_SEEDS+1];
  logic [COORD_BITS-1:0] pos_y    [MAX_SEEDS+1];
  logic [RGB_W-1:0]      rgb      [MAX_SEEDS+1];
  logic [D_W-1:0]        best_d   [MAX_SEEDS+1];
  logic [IDX_W-1:0]      best_i   [MAX_SEEDS+1];
  logic [RGB_W-1:0]      best_rgb [MAX_SEEDS+1];

  logic                  adv;
  logic                  out_valid_r;
  logic                  out_marker_r;
  logic [RGB_W-1:0]      out_rgb_r;
  logic [IDX_OUT_W-1:0]  out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r    <= RESET_SEED_COUNT;
      marker_radius_r <= RESET_MARKER_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_COUNT:    seed_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_MARKER_RADIUS: marker_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    ctl[0].valid      = in_ch.valid;
    ctl[0].load       = (in_ch.op == OP_LOAD);
    ctl[0].marker     = 1'b0;
    ctl[0].seed_index = in_ch.seed_index;
    pos_x[0]          = in_ch.pos_x;
    pos_y[0]          = in_ch.pos_y;
    rgb[0]            = {in_ch.load_red, in_ch.load_green, in_ch.load_blue};
    best_d[0]         = '1;
    best_i[0]         = '0;
    best_rgb[0]       = '0;
  end

  for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
    vns_cell #(
      .CELL_ID    (g),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .adv           (adv),
      .seed_count    (seed_count_r),
      .marker_radius (marker_radius_r),
      .ctl_i         (ctl[g]),
      .pos_x_i       (pos_x[g]),
      .pos_y_i       (pos_y[g]),
      .rgb_i         (rgb[g]),
      .best_d_i      (best_d[g]),
      .best_i_i      (best_i[g]),
      .best_rgb_i    (best_rgb[g]),
      .ctl_o         (ctl[g+1]),
      .pos_x_o       (pos_x[g+1]),
      .pos_y_o       (pos_y[g+1]),
      .rgb_o         (rgb[g+1]),
      .best_d_o      (best_d[g+1]),
      .best_i_o      (best_i[g+1]),
      .best_rgb_o    (best_rgb[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl[MAX_SEEDS].valid && !ctl[MAX_SEEDS].load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_marker_r <= ctl[MAX_SEEDS].marker;
      out_rgb_r    <= ctl[MAX_SEEDS].marker ? '0 : best_rgb[MAX_SEEDS];
      out_idx_r    <= IDX_OUT_W'(best_i[MAX_SEEDS]);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_red     = out_rgb_r[3*CHAN_W-1:2*CHAN_W];
  assign out_ch.pixel_green   = out_rgb_r[2*CHAN_W-1:CHAN_W];
  assign out_ch.pixel_blue    = out_rgb_r[CHAN_W-1:0];
  assign out_ch.nearest_index = out_idx_r;
  assign out_ch.on_marker     = out_marker_r;

  a_marker_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.on_marker |->
      (out_ch.pixel_red == '0 && out_ch.pixel_green == '0 && out_ch.pixel_blue == '0))
    else $error("marker pixel not black");

  a_index_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.nearest_index == '0 || {1'b0, out_ch.nearest_index} < seed_count_r))
    else $error("nearest index beyond seeds in use");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctl[MAX_SEEDS]) && $stable(best_i[MAX_SEEDS]))
    else $error("chain advanced during stall");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl[MAX_SEEDS].valid && ctl[MAX_SEEDS].load |=> !out_ch.valid)
    else $error("load word produced a result");

endmodule

/* sim/tb_voronoi_nearest_seed_shader.sv */
// Self-checking testbench of the Voronoi nearest-seed shader: directed table, then random phases.
module tb_voronoi_nearest_seed_shader;
  import vns_pkg::*;

  localparam int MAX_SEEDS    = DEF_MAX_SEEDS;
  localparam int COORD_BITS   = DEF_COORD_BITS;
  localparam int LATENCY      = MAX_SEEDS + 1;
  localparam int RANDOM_WORDS = 1420;
  localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
  localparam logic [RAD_W-1:0]      RADIUS_MAX = '1;

  typedef struct packed {
    logic                  op;
    logic [IDX_OUT_W-1:0]  seed_index;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
  } seed_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [IDX_OUT_W-1:0] nearest;
    logic                 marker;
  } pixel_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    seed_word_t            word;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    pixel_t                pixel;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vns_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  vns_out_if                           out_ch ();

  voronoi_nearest_seed_shader #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [COORD_BITS-1:0] seed_x   [MAX_SEEDS];
  logic [COORD_BITS-1:0] seed_y   [MAX_SEEDS];
  logic [RGB_W-1:0]      seed_rgb [MAX_SEEDS];
  logic [CNT_W-1:0]      seed_count;
  logic [RAD_W-1:0]      marker_radius;

  pixel_t    expected_pixels [$];
  stim_row_t directed_rows [$];
  int        err_count;
  bit        in_quiet;
  bit        out_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int seeds_in_use();
    int n;
    n = int'(seed_count);
    if (n == 0) n = 1;
    if (n > MAX_SEEDS) n = MAX_SEEDS;
    return n;
  endfunction

  function automatic pixel_t nearest_seed_pixel(logic [COORD_BITS-1:0] x,
                                                logic [COORD_BITS-1:0] y);
    pixel_t           p;
    longint           best;
    longint           d;
    longint           dx;
    longint           dy;
    int               best_i;
    bit               hit;
    logic [RGB_W-1:0] rgb;
    best   = 0;
    best_i = 0;
    hit    = 1'b0;
    for (int i = 0; i < seeds_in_use(); i++) begin
      dx = longint'(x) - longint'(seed_x[i]);
      dy = longint'(y) - longint'(seed_y[i]);
      d  = dx * dx + dy * dy;
      if (i == 0 || d < best) begin
        best   = d;
        best_i = i;
      end
      if (d <= longint'(marker_radius)) hit = 1'b1;
    end
    rgb       = hit ? '0 : seed_rgb[best_i];
    p.red     = rgb[23:16];
    p.green   = rgb[15:8];
    p.blue    = rgb[7:0];
    p.nearest = best_i[IDX_OUT_W-1:0];
    p.marker  = hit;
    return p;
  endfunction

  task automatic apply_word(seed_word_t w, bit typed, pixel_t typed_pixel);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= w.op;
    in_ch.seed_index <= w.seed_index;
    in_ch.pos_x      <= w.pos_x;
    in_ch.pos_y      <= w.pos_y;
    in_ch.load_red   <= w.red;
    in_ch.load_green <= w.green;
    in_ch.load_blue  <= w.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (w.op == OP_LOAD) begin
      seed_x[w.seed_index]   = w.pos_x;
      seed_y[w.seed_index]   = w.pos_y;
      seed_rgb[w.seed_index] = {w.red, w.green, w.blue};
    end else begin
      expected_pixels.push_back(typed ? typed_pixel : nearest_seed_pixel(w.pos_x, w.pos_y));
    end
  endtask

  task automatic write_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    // let trailing load words leave the chain
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_SEED_COUNT) seed_count = value[CNT_W-1:0];
    else marker_radius = value[RAD_W-1:0];
  endtask

  function automatic void add_load(int idx, int x, int y, int r, int g, int b);
    stim_row_t row;
    row                 = '0;
    row.kind            = ROW_WORD;
    row.word.op         = OP_LOAD;
    row.word.seed_index = IDX_OUT_W'(idx);
    row.word.pos_x      = COORD_BITS'(x);
    row.word.pos_y      = COORD_BITS'(y);
    row.word.red        = CHAN_W'(r);
    row.word.green      = CHAN_W'(g);
    row.word.blue       = CHAN_W'(b);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_shade(int x, int y, int idx);
    stim_row_t row;
    row                 = '0;
    row.kind            = ROW_WORD;
    row.word.op         = OP_SHADE;
    row.word.seed_index = IDX_OUT_W'(idx);
    row.word.pos_x      = COORD_BITS'(x);
    row.word.pos_y      = COORD_BITS'(y);
    row.word.red        = 8'hFF;
    row.word.green      = 8'hFF;
    row.word.blue       = 8'hFF;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_shade_exp(int x, int y, int r, int g, int b, int n, int m);
    stim_row_t row;
    row               = '0;
    row.kind          = ROW_WORD;
    row.word.op       = OP_SHADE;
    row.word.pos_x    = COORD_BITS'(x);
    row.word.pos_y    = COORD_BITS'(y);
    row.typed         = 1'b1;
    row.pixel.red     = CHAN_W'(r);
    row.pixel.green   = CHAN_W'(g);
    row.pixel.blue    = CHAN_W'(b);
    row.pixel.nearest = IDX_OUT_W'(n);
    row.pixel.marker  = m[0];
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, int value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.value   = CFG_DATA_W'(value);
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    add_cfg(CFG_SEED_COUNT, 1);
    add_load(0, 0, 0, 'hFF, 'h00, 'h80);
    add_shade_exp(1023, 1023, 'hFF, 'h00, 'h80, 0, 0);
    add_shade_exp(3, 1, 0, 0, 0, 0, 1);
    add_shade_exp(3, 2, 'hFF, 'h00, 'h80, 0, 0);
    // zero count still uses entry zero
    add_cfg(CFG_SEED_COUNT, 0);
    add_load(63, 1023, 1023, 'h01, 'h02, 'h03);
    add_shade_exp(1023, 1023, 'hFF, 'h00, 'h80, 0, 0);
    add_cfg(CFG_MARKER_RADIUS, 0);
    add_shade_exp(0, 0, 0, 0, 0, 0, 1);
    add_shade_exp(0, 1, 'hFF, 'h00, 'h80, 0, 0);
    add_cfg(CFG_MARKER_RADIUS, RADIUS_MAX);
    add_shade_exp(1023, 1023, 0, 0, 0, 0, 1);
    // oversized count saturates to the full table
    add_cfg(CFG_SEED_COUNT, 127);
    add_load(1, 1023, 0, 'hAA, 'hBB, 'hCC);
    add_shade(1023, 1023, 0);
    add_cfg(CFG_MARKER_RADIUS, 10);
    add_shade(1023, 0, 0);
    add_shade(0, 1023, 0);
    add_cfg(CFG_SEED_COUNT, MAX_SEEDS);
    add_load(5, 500, 500, 'h11, 'h22, 'h33);
    add_load(6, 500, 500, 'h44, 'h55, 'h66);
    add_shade(520, 500, 0);
    add_shade(500, 500, 0);
    add_shade(511, 511, 63);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(MAX_SEEDS);
      3: return CFG_DATA_W'($urandom_range(MAX_SEEDS + 1, 127));
      default: return CFG_DATA_W'($urandom_range(2, MAX_SEEDS - 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_radius();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return RADIUS_MAX;
      2: return CFG_DATA_W'($urandom_range(0, 20));
      3: return CFG_DATA_W'($urandom_range(0, 2000));
      4: return CFG_DATA_W'($urandom_range(0, RADIUS_MAX));
      default: return CFG_DATA_W'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic seed_word_t random_word();
    seed_word_t w;
    int         src;
    int         pick;
    w.seed_index = IDX_OUT_W'($urandom);
    w.pos_x      = COORD_BITS'($urandom);
    w.pos_y      = COORD_BITS'($urandom);
    w.red        = CHAN_W'($urandom);
    w.green      = CHAN_W'($urandom);
    w.blue       = CHAN_W'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      w.op = OP_LOAD;
      // duplicate a position to force distance ties
      if ($urandom_range(0, 3) == 0) begin
        src     = $urandom_range(0, MAX_SEEDS - 1);
        w.pos_x = seed_x[src];
        w.pos_y = seed_y[src];
      end
    end else begin
      w.op = OP_SHADE;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        src     = $urandom_range(0, seeds_in_use() - 1);
        w.pos_x = seed_x[src] + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
        w.pos_y = seed_y[src] + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
      end else if (pick == 4) begin
        w.pos_x = $urandom_range(0, 1) ? COORD_MAX : '0;
        w.pos_y = $urandom_range(0, 1) ? COORD_MAX : '0;
      end
    end
    return w;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result word with no pixel expected");
        err_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_red", int'(want.red), int'(out_ch.pixel_red));
        check_field("pixel_green", int'(want.green), int'(out_ch.pixel_green));
        check_field("pixel_blue", int'(want.blue), int'(out_ch.pixel_blue));
        check_field("nearest_index", int'(want.nearest), int'(out_ch.nearest_index));
        check_field("on_marker", int'(want.marker), int'(out_ch.on_marker));
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         sent;
    int         n;
    seed_word_t w;
    pixel_t     none;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_LOAD;
    in_ch.seed_index <= '0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.load_red   <= '0;
    in_ch.load_green <= '0;
    in_ch.load_blue  <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SEED_COUNT;
    cfg_wdata        <= '0;
    in_quiet      = 1'b0;
    out_quiet     = 1'b0;
    err_count     = 0;
    none          = '0;
    seed_count    = RESET_SEED_COUNT;
    marker_radius = RESET_MARKER_RADIUS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every entry so no shade reads unwritten storage
    for (int i = 0; i < MAX_SEEDS; i++) begin
      w            = random_word();
      w.op         = OP_LOAD;
      w.seed_index = IDX_OUT_W'(i);
      w.pos_x      = COORD_BITS'($urandom);
      w.pos_y      = COORD_BITS'($urandom);
      apply_word(w, 1'b0, none);
    end

    build_directed();
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_cfg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        apply_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].pixel);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      write_cfg(CFG_SEED_COUNT, random_count());
      if ($urandom_range(0, 1)) write_cfg(CFG_MARKER_RADIUS, random_radius());
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 120);
      repeat (n) apply_word(random_word(), 1'b0, none);
      sent += n;
    end

    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hdl/vns_pkg.sv
hdl/vns_if.sv
hdl/vns_cell.sv
hdl/voronoi_nearest_seed_shader.sv
sim/tb_voronoi_nearest_seed_shader.sv
